[hw/rtl/eg3x3_pkg.sv]
// ----------------------------------------------------------------------------
// eg3x3_pkg: shared definitions of the 3x3 edge gradient unit
// Frame limits, field widths, register indexes, operator codes and the
// saturating absolute value used by all three operators.
// ----------------------------------------------------------------------------
package eg3x3_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // Column address into the line store and the row counter.
  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);

  // Geometry registers, and internal geometry arithmetic.
  localparam int unsigned DIM_W  = 11;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned POS_W  = 10;

  // Signed width of a gradient: sums reach 4 * 255 either way.
  localparam int unsigned GRAD_W = 12;

  localparam logic [DIM_W-1:0] MIN_DIM     = DIM_W'(3);
  localparam logic [DIM_W-1:0] MAX_W_DIM   = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM   = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] WIDTH_RST   = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST  = DIM_W'(480);

  typedef enum logic [IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_PREWITT   = 2'd0,
    MODE_SOBEL     = 2'd1,
    MODE_LAPLACIAN = 2'd2
  } mode_e;

  // Bookkeeping that travels with one pixel through the pipeline.
  typedef struct packed {
    logic             emit;   // the pixel produces a result
    logic             zero;   // border centre, score forced to zero
    logic             done;   // last result of the frame
    logic [POS_W-1:0] row;    // centre row
    logic [POS_W-1:0] col;    // centre column
  } tag_t;

  function automatic logic [PIX_W-1:0] abs_sat(input logic signed [GRAD_W-1:0] v);
    logic [GRAD_W-1:0] a;
    a = v[GRAD_W-1] ? GRAD_W'(-v) : GRAD_W'(v);
    return (a > GRAD_W'(255)) ? {PIX_W{1'b1}} : a[PIX_W-1:0];
  endfunction

endpackage

[hw/rtl/edge_gradient_3x3_unit.sv]
// ----------------------------------------------------------------------------
// edge_gradient_3x3_unit: streaming 3x3 edge strength for 8-bit grey frames
// Scores every pixel of a raster stream with Prewitt, Sobel or Laplacian.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock in raster order and, once the pipeline
// is full, delivers one result per clock: a new pixel transfer can complete
// in every cycle as long as the result side keeps up. The pixel at row r and
// column c (both at least 1) yields the score of centre (r-1, c-1); pixels in
// row 0 or column 0 yield nothing, and centres in row 0 or column 0 score 0.
// The pixel transfer itself captures the line store read into stage 1, the
// stage 2 window updates from it, and the output register then takes the
// score; a waiting result can hold a pixel in either stage. The two previous
// rows live in one 1024 x 16-bit RAM with one read and one write per cycle;
// a read of the column that is being written in the same cycle is served
// from a bypass register. The line store needs no clearing after reset.
// Frame geometry and operator are set through the configuration port; the
// user must do so only while the unit is idle, the unit does not enforce it.
// ----------------------------------------------------------------------------
module edge_gradient_3x3_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [eg3x3_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [eg3x3_pkg::DIM_W-1:0]    cfg_data_i,
  // pixel stream
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [eg3x3_pkg::PIX_W-1:0]    pixel_i,
  input  logic                           frame_start_i,
  // result stream
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [eg3x3_pkg::PIX_W-1:0]    edge_res_o,
  output logic [eg3x3_pkg::POS_W-1:0]    out_row_o,
  output logic [eg3x3_pkg::POS_W-1:0]    out_col_o,
  output logic                           frame_done_o
);
  import eg3x3_pkg::*;

  // Configuration registers.
  logic [MODE_W-1:0] mode_q;
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;

  // Raster position of the next pixel.
  logic [ADDR_W-1:0] col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;

  // Stage 1: line store read in flight.
  logic              s1_valid_q;
  logic [PIX_W-1:0]  s1_pix_q;
  logic [ADDR_W-1:0] s1_col_q;
  tag_t              s1_tag_q;
  logic              byp_q;
  logic [2*PIX_W-1:0] byp_data_q;
  logic [2*PIX_W-1:0] rd_q;

  // Stage 2: window holds the neighborhood of the centre.
  logic              s2_valid_q;
  tag_t              s2_tag_q;
  logic [PIX_W-1:0]  win_q [3][3];

  // Output register.
  logic              out_valid_q;
  logic [PIX_W-1:0]  edge_q;
  tag_t              out_tag_q;

  // Line store: upper row in the high byte, middle row in the low byte.
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

  logic              out_en, s2_en, s1_en, accept;
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [DIM_W-1:0]  c0, r0, c1, r1, c_cur, r_cur;
  tag_t              tag_new;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  s1_up, s1_mid;
  logic [2*PIX_W-1:0] wr_data;
  logic              byp_hit;
  logic [PIX_W-1:0]  score;

  // ---------------------------------------------------------------------------
  // Handshakes. Each stage moves on when the stage after it is empty or moves
  // on too, so a waiting result does not stop pixels from filling the pipeline.
  // ---------------------------------------------------------------------------
  assign out_en      = !out_valid_q || out_ready_i;
  assign s2_en       = !s2_valid_q || out_en;
  assign s1_en       = !s1_valid_q || s2_en;
  assign in_ready_o  = s1_en;
  assign accept      = in_valid_i && s1_en;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Geometry: out-of-range sizes are clamped to the supported range.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (width_q < MIN_DIM) begin
      w_eff = MIN_DIM;
    end else if (width_q > MAX_W_DIM) begin
      w_eff = MAX_W_DIM;
    end else begin
      w_eff = width_q;
    end
    if (height_q < MIN_DIM) begin
      h_eff = MIN_DIM;
    end else if (height_q > MAX_H_DIM) begin
      h_eff = MAX_H_DIM;
    end else begin
      h_eff = height_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Position of the incoming pixel. A frame start restarts at the origin, and
  // a position left outside a narrowed frame wraps to the next row or to row 0.
  // ---------------------------------------------------------------------------
  always_comb begin
    c0 = frame_start_i ? '0 : DIM_W'(col_q);
    r0 = frame_start_i ? '0 : DIM_W'(row_q);
    if (c0 >= w_eff) begin
      c1 = '0;
      r1 = r0 + DIM_W'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    c_cur = c1;
    r_cur = (r1 >= h_eff) ? '0 : r1;

    if (c_cur + DIM_W'(1) >= w_eff) begin
      col_d = '0;
      row_d = (r_cur + DIM_W'(1) >= h_eff) ? '0 : ROW_W'(r_cur + DIM_W'(1));
    end else begin
      col_d = ADDR_W'(c_cur + DIM_W'(1));
      row_d = ROW_W'(r_cur);
    end

    tag_new.emit = (r_cur != '0) && (c_cur != '0);
    tag_new.zero = (r_cur == DIM_W'(1)) || (c_cur == DIM_W'(1));
    tag_new.done = (r_cur == h_eff - DIM_W'(1)) && (c_cur == w_eff - DIM_W'(1));
    tag_new.row  = POS_W'(r_cur - DIM_W'(1));
    tag_new.col  = POS_W'(c_cur - DIM_W'(1));
    rd_addr      = ADDR_W'(c_cur);
  end

  // ---------------------------------------------------------------------------
  // Stage 1 data. The column just written by the previous pixel may be read
  // again right away (a repeated frame start at column 0); that read takes the
  // bypass copy instead of the stale RAM word.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (byp_q) begin
      s1_up  = byp_data_q[2*PIX_W-1:PIX_W];
      s1_mid = byp_data_q[PIX_W-1:0];
    end else begin
      s1_up  = rd_q[2*PIX_W-1:PIX_W];
      s1_mid = rd_q[PIX_W-1:0];
    end
    // The middle row moves up, the new pixel becomes the middle row.
    wr_data = {s1_mid, s1_pix_q};
    byp_hit = s1_valid_q && s2_en && (s1_col_q == rd_addr);
  end

  // Line store RAM: written when stage 1 retires, read when a pixel enters.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_en) begin
      line_mem[s1_col_q] <= wr_data;
    end
    if (accept) begin
      rd_q <= line_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Scoring of the window. Prewitt and Sobel average the two saturated
  // gradient magnitudes; Laplacian uses the four direct neighbors. The code
  // that names no operator scores as Laplacian.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic signed [GRAD_W-1:0] top, bot, lft, rgt, gx, gy, lap;
    logic [PIX_W-1:0]         ax, ay;
    logic [PIX_W:0]           gsum;
    logic                     sobel;

    sobel = (mode_e'(mode_q) == MODE_SOBEL);
    top = GRAD_W'(win_q[0][0]) + GRAD_W'(win_q[0][2])
        + (sobel ? GRAD_W'(win_q[0][1]) << 1 : GRAD_W'(win_q[0][1]));
    bot = GRAD_W'(win_q[2][0]) + GRAD_W'(win_q[2][2])
        + (sobel ? GRAD_W'(win_q[2][1]) << 1 : GRAD_W'(win_q[2][1]));
    lft = GRAD_W'(win_q[0][0]) + GRAD_W'(win_q[2][0])
        + (sobel ? GRAD_W'(win_q[1][0]) << 1 : GRAD_W'(win_q[1][0]));
    rgt = GRAD_W'(win_q[0][2]) + GRAD_W'(win_q[2][2])
        + (sobel ? GRAD_W'(win_q[1][2]) << 1 : GRAD_W'(win_q[1][2]));
    gx  = bot - top;
    gy  = rgt - lft;
    lap = GRAD_W'(win_q[0][1]) + GRAD_W'(win_q[2][1])
        + GRAD_W'(win_q[1][0]) + GRAD_W'(win_q[1][2])
        - (GRAD_W'(win_q[1][1]) << 2);
    ax   = abs_sat(gx);
    ay   = abs_sat(gy);
    gsum = {1'b0, ax} + {1'b0, ay};

    case (mode_e'(mode_q))
      MODE_PREWITT,
      MODE_SOBEL: begin
        score = gsum[PIX_W:1];
      end
      MODE_LAPLACIAN: begin
        score = abs_sat(lap);
      end
      default: begin
        score = abs_sat(lap);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control state: configuration, raster counters, stage valid flags.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SOBEL;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      if (cfg_valid_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
          REG_WIDTH:  width_q  <= cfg_data_i;
          REG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        byp_q <= byp_hit;
      end
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
        // The window slides one column as the stage 1 pixel retires.
        if (s1_valid_q) begin
          for (int i = 0; i < 3; i++) begin
            win_q[i][0] <= win_q[i][1];
            win_q[i][1] <= win_q[i][2];
          end
          win_q[0][2] <= s1_up;
          win_q[1][2] <= s1_mid;
          win_q[2][2] <= s1_pix_q;
        end
      end
      if (out_en) begin
        out_valid_q <= s2_valid_q && s2_tag_q.emit;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= pixel_i;
      s1_col_q <= rd_addr;
      s1_tag_q <= tag_new;
      if (byp_hit) begin
        byp_data_q <= wr_data;
      end
    end
    if (s2_en && s1_valid_q) begin
      s2_tag_q <= s1_tag_q;
    end
    if (out_en && s2_valid_q) begin
      edge_q    <= s2_tag_q.zero ? '0 : score;
      out_tag_q <= s2_tag_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign edge_res_o   = edge_q;
  assign out_row_o    = out_tag_q.row;
  assign out_col_o    = out_tag_q.col;
  assign frame_done_o = out_tag_q.done;

endmodule

[dv/edge_gradient_checker.sv]
// ----------------------------------------------------------------------------
// edge_gradient_checker: result scoreboard of the 3x3 edge gradient unit
// Follows the register writes and pixel transfers, predicts every result
// transfer and compares it, in order, with what the unit delivers.
// ----------------------------------------------------------------------------
module edge_gradient_checker
  import eg3x3_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [IDX_W-1:0]   cfg_index_i,
  input  logic [DIM_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [PIX_W-1:0]   pixel_i,
  input  logic               frame_start_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic [PIX_W-1:0]   edge_res_i,
  input  logic [POS_W-1:0]   out_row_i,
  input  logic [POS_W-1:0]   out_col_i,
  input  logic               frame_done_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [PIX_W-1:0] edge_res;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             done;
  } edge_result_t;

  edge_result_t     expected_edges[$];
  logic [PIX_W-1:0] upper_line  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_line [MAX_WIDTH];
  logic [PIX_W-1:0] win [3][3];
  int unsigned      row_cnt;
  int unsigned      col_cnt;
  mode_e            op_mode;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned limit);
    if (v < 3) return 3;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] sat_mag(int v);
    int m;
    m = (v < 0) ? -v : v;
    return (m > 255) ? {PIX_W{1'b1}} : PIX_W'(m);
  endfunction

  function automatic logic [PIX_W-1:0] window_score();
    int p [3][3];
    int k;
    int gx;
    int gy;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p[r][c] = int'(win[r][c]);
      end
    end
    // The upper mode bit selects the Laplacian, so code 3 scores like code 2.
    if (op_mode[1]) begin
      return sat_mag(p[0][1] + p[2][1] + p[1][0] + p[1][2] - 4 * p[1][1]);
    end
    k  = (op_mode == MODE_SOBEL) ? 2 : 1;
    gx = (p[2][0] + k * p[2][1] + p[2][2]) - (p[0][0] + k * p[0][1] + p[0][2]);
    gy = (p[0][2] + k * p[1][2] + p[2][2]) - (p[0][0] + k * p[1][0] + p[2][0]);
    return PIX_W'((int'(sat_mag(gx)) + int'(sat_mag(gy))) >> 1);
  endfunction

  function automatic void predict_edge(logic [PIX_W-1:0] pix, logic fs);
    int unsigned  w;
    int unsigned  h;
    int unsigned  r;
    int unsigned  c;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    edge_result_t res;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (fs) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    // A geometry change may leave the counters outside the new frame.
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    r = row_cnt;
    c = col_cnt;

    up  = upper_line[c];
    mid = middle_line[c];
    upper_line[c]  = mid;
    middle_line[c] = pix;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = pix;

    if (r >= 1 && c >= 1) begin
      res.edge_res = (r == 1 || c == 1) ? '0 : window_score();
      res.row      = POS_W'(r - 1);
      res.col      = POS_W'(c - 1);
      res.done     = (r == h - 1) && (c == w - 1);
      expected_edges.push_back(res);
    end

    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  function automatic void note_failure(string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    edge_result_t got;
    edge_result_t want;
    if (!rst_ni) begin
      expected_edges.delete();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] = '0;
        end
      end
      row_cnt      = 0;
      col_cnt      = 0;
      op_mode      = MODE_SOBEL;
      width_reg    = WIDTH_RST;
      height_reg   = HEIGHT_RST;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MODE:   op_mode    = mode_e'(cfg_data_i[MODE_W-1:0]);
          REG_WIDTH:  width_reg  = cfg_data_i;
          REG_HEIGHT: height_reg = cfg_data_i;
          default:    ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_edge(pixel_i, frame_start_i);
      if (res_valid_i && res_ready_i) begin
        got = {edge_res_i, out_row_i, out_col_i, frame_done_i};
        if (expected_edges.size() == 0) begin
          note_failure($sformatf("unexpected edge result: edge %0d row %0d col %0d done %0b",
                                 got.edge_res, got.row, got.col, got.done));
        end else begin
          want = expected_edges.pop_front();
          if (got.edge_res !== want.edge_res || got.row !== want.row ||
              got.col !== want.col || got.done !== want.done) begin
            note_failure($sformatf({"edge result mismatch: expected edge %0d row %0d col %0d",
                                    " done %0b, got edge %0d row %0d col %0d done %0b"},
                                   want.edge_res, want.row, want.col, want.done,
                                   got.edge_res, got.row, got.col, got.done));
          end
        end
      end
      pending_o = expected_edges.size();
    end
  end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the 3x3 edge gradient unit
// Streams grey frames of many geometries and operators through the unit with
// random sender bursts and receiver stalls; a separate checker predicts and
// compares every result transfer.
// ----------------------------------------------------------------------------
module tb_top;
  import eg3x3_pkg::*;

  // Index that selects no register; a write to it must leave every setting alone.
  localparam logic [IDX_W-1:0]  REG_UNUSED     = 2'd3;
  // Operator code outside the named set; it has to score like the Laplacian.
  localparam logic [MODE_W-1:0] MODE_ALIAS_LAP = 2'd3;

  // Directed 3x3 frames, first pixel in the top byte.
  localparam logic [9*PIX_W-1:0] SPOT_BRIGHT = {8'd0,   8'd0,   8'd0,
                                                8'd0,   8'd255, 8'd0,
                                                8'd0,   8'd0,   8'd0};
  localparam logic [9*PIX_W-1:0] SPOT_DARK   = {8'd255, 8'd255, 8'd255,
                                                8'd255, 8'd0,   8'd255,
                                                8'd255, 8'd255, 8'd255};
  localparam logic [9*PIX_W-1:0] SLOPE       = {8'd200, 8'd90,  8'd10,
                                                8'd60,  8'd30,  8'd5,
                                                8'd0,   8'd0,   8'd255};

  typedef enum int unsigned {TEX_NOISE, TEX_BINARY, TEX_SMOOTH} texture_e;
  typedef enum int unsigned {FLOW_OPEN, FLOW_RANDOM, FLOW_DUTY, FLOW_BURSTY} flow_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [IDX_W-1:0]   cfg_index_i;
  logic [DIM_W-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [PIX_W-1:0]   pixel_i;
  logic               frame_start_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [PIX_W-1:0]   edge_res_o;
  logic [POS_W-1:0]   out_row_o;
  logic [POS_W-1:0]   out_col_o;
  logic               frame_done_o;

  int                 fail_count;
  int                 pending;

  // Sender pacing: a burst of transfers, then a random pause of up to gap_max.
  int unsigned        burst_left;
  int unsigned        gap_max;
  // Receiver pacing, chosen per phase.
  flow_e              flow;
  int unsigned        stall_run;
  int unsigned        tick;

  logic [PIX_W-1:0]   last_pixel;
  int unsigned        shadow_w;
  int unsigned        shadow_h;
  // Columns below this mark hold written data in both line stores. Reading
  // beyond it at a scored centre would expose uninitialized RAM, so a wider
  // frame always opens with frame_start until three unbroken full rows have passed.
  int unsigned        defined_cols;
  int unsigned        random_items;

  edge_gradient_3x3_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .edge_res_o    (edge_res_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .frame_done_o  (frame_done_o)
  );

  edge_gradient_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .res_valid_i   (out_valid_o),
    .res_ready_i   (out_ready_i),
    .edge_res_i    (edge_res_o),
    .out_row_i     (out_row_o),
    .out_col_i     (out_col_o),
    .frame_done_i  (frame_done_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // This timeout only trips on a hang: the slowest legal run, with every pause
  // and stall at its longest, ends before it.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Receiver side. It stalls on a pattern of its own that changes per phase:
  // always ready, random stalls, a fixed duty cycle, or rare but
  // long stalls that back the whole pipeline up into the pixel channel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_run   = 0;
      tick        = 0;
    end else begin
      tick++;
      case (flow)
        FLOW_OPEN:   out_ready_i <= 1'b1;
        FLOW_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
        FLOW_DUTY:   out_ready_i <= ((tick % 9) > 2);
        default: begin
          if (stall_run != 0) begin
            stall_run--;
            out_ready_i <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_run = $urandom_range(1, 24);
            out_ready_i <= 1'b0;
          end else begin
            out_ready_i <= 1'b1;
          end
        end
      endcase
    end
  end

  // Puts one write on the configuration channel and waits for its transfer.
  // Valid stays high so that back-to-back writes need no second assignment.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Writes the selected registers: bit 0 operator, bit 1 width, bit 2 height,
  // bit 3 a write to the unused index. Only called while the unit is idle.
  task automatic apply_setup(input logic [MODE_W-1:0] op, input logic [DIM_W-1:0] w,
                             input logic [DIM_W-1:0] h, input logic [3:0] which);
    if (which[0]) write_reg(REG_MODE, DIM_W'(op));
    if (which[1]) begin
      write_reg(REG_WIDTH, w);
      shadow_w = (w < 3) ? 3 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    end
    if (which[2]) begin
      write_reg(REG_HEIGHT, h);
      shadow_h = (h < 3) ? 3 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    end
    if (which[3]) write_reg(REG_UNUSED, DIM_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Offers one pixel and returns at the edge of its transfer. A new burst may
  // start with a pause; valid is only dropped when that pause is non-empty.
  task automatic push_pixel(input logic [PIX_W-1:0] value, input logic fs);
    int unsigned pause;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      pause      = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (pause != 0) begin
        in_valid_i <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    pixel_i       <= value;
    frame_start_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(texture_e tex);
    int v;
    case (tex)
      TEX_NOISE:  last_pixel = PIX_W'($urandom);
      TEX_BINARY: last_pixel = ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: begin
        // Gentle ramps keep the gradients small and unsaturated.
        v = int'(last_pixel) + int'($urandom_range(0, 40)) - 20;
        last_pixel = (v < 0) ? '0 : (v > 255) ? '1 : PIX_W'(v);
      end
    endcase
    return last_pixel;
  endfunction

  // Streams n pixels. With restarts allowed, a stray frame_start now and then
  // cuts a frame short; broke reports whether that happened.
  task automatic stream_pixels(input int unsigned n, input texture_e tex,
                               input logic first_fs, input logic restarts,
                               output logic broke);
    logic fs;
    broke = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      fs = (i == 0) ? first_fs : (restarts && $urandom_range(0, 59) == 0);
      if (i != 0 && fs) broke = 1'b1;
      push_pixel(pick_pixel(tex), fs);
    end
  endtask

  task automatic send_frame(input logic [9*PIX_W-1:0] pix, input logic fs_first);
    for (int i = 0; i < 9; i++) begin
      push_pixel(pix[9*PIX_W-1-PIX_W*i -: PIX_W], fs_first && i == 0);
    end
  endtask

  // Waits for every predicted result, then lets the pipeline run empty: the
  // last pixels streamed may yield no result but still be in flight.
  task automatic drain_results();
    in_valid_i    <= 1'b0;
    frame_start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [DIM_W-1:0] w_val;
    logic [DIM_W-1:0] h_val;
    logic             first_fs;
    logic             broke;
    int unsigned      n;
    int unsigned      top;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_MODE;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    pixel_i       = '0;
    frame_start_i = 1'b0;
    burst_left    = 0;
    gap_max       = 0;
    flow          = FLOW_OPEN;
    last_pixel    = '0;
    shadow_w      = WIDTH_RST;
    shadow_h      = HEIGHT_RST;
    defined_cols  = 0;
    random_items  = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames on the smallest geometry. Width 0 and height 2 both
    // count as 3, and the unused index is written once to prove it is ignored.
    // A lone bright pixel on black drives the Laplacian far below zero.
    apply_setup(MODE_LAPLACIAN, '0, DIM_W'(2), 4'b1111);
    send_frame(SPOT_BRIGHT, 1'b1);
    drain_results();
    // The negative image on the alias code, with no frame_start: the counters
    // must already have wrapped at the end of the previous frame.
    apply_setup(MODE_ALIAS_LAP, '0, '0, 4'b0001);
    send_frame(SPOT_DARK, 1'b0);
    drain_results();
    // A steep slope under Sobel, with both gradients below saturation.
    apply_setup(MODE_SOBEL, '0, '0, 4'b0001);
    send_frame(SLOPE, 1'b1);
    drain_results();
    defined_cols = 3;

    // Random phases. Each picks a geometry, operator, texture and pacing, then
    // streams one row to three frames. Some phases write nothing or resume
    // without frame_start, exercising counters left outside a shrunken frame.
    while (random_items < 700) begin
      case ($urandom_range(0, 9))
        0:       w_val = DIM_W'($urandom_range(0, 2));
        1:       w_val = DIM_W'($urandom_range(13, 40));
        default: w_val = DIM_W'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       h_val = DIM_W'($urandom_range(0, 2));
        1:       h_val = DIM_W'($urandom_range(9, 20));
        default: h_val = DIM_W'($urandom_range(3, 8));
      endcase
      apply_setup(MODE_W'($urandom_range(0, 3)), w_val, h_val, 4'($urandom_range(0, 15)));

      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      flow    = flow_e'($urandom_range(0, 3));
      top     = 3 * shadow_w * shadow_h;
      if (top > 400) top = 400;
      n        = $urandom_range(shadow_w, top);
      first_fs = (shadow_w > defined_cols) || ($urandom_range(0, 2) != 0);
      stream_pixels(n, texture_e'($urandom_range(0, 2)), first_fs, 1'b1, broke);
      if (!broke && n >= 3 * shadow_w && shadow_w > defined_cols) defined_cols = shadow_w;
      random_items += n;
      drain_results();
    end

    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
